// ===== hdl/sefr_pkg.sv =====
package sefr_pkg;

  localparam logic [7:0] SYNC_BYTE  = 8'hE0;
  localparam logic [7:0] MARK_BYTE  = 8'hD0;
  localparam logic [7:0] BCAST_ADDR = 8'hFF;
  localparam logic [7:0] NODE_ADDR_RESET = 8'hFF;

  localparam int unsigned POS_W  = 9;
  localparam int unsigned BYTE_W = 8;

  typedef enum logic [1:0] {
    ST_BUSY   = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_SUMERR = 2'd2,
    ST_OTHER  = 2'd3
  } frame_status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [POS_W-1:0]  byte_pos;
    logic              frame_end;
    frame_status_t     frame_status;
  } result_t;

endpackage

// ===== hdl/sefr_in_reg.sv =====
module sefr_in_reg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sefr_pkg::BYTE_W-1:0]  in_byte,
  output logic                         item_valid,
  output logic [sefr_pkg::BYTE_W-1:0]  item_byte,
  input  logic                         item_advance
);

  logic                        valid_r;
  logic                        valid_nxt;
  logic [sefr_pkg::BYTE_W-1:0] byte_r;

  assign in_ready   = !valid_r || item_advance;
  assign item_valid = valid_r && item_advance;
  assign item_byte  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

endmodule

// ===== hdl/sefr_frame_fsm.sv =====
module sefr_frame_fsm (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_valid,
  input  logic [sefr_pkg::BYTE_W-1:0]  item_byte,
  input  logic [sefr_pkg::BYTE_W-1:0]  node_address,
  output logic                         res_valid,
  output sefr_pkg::result_t            res
);

  logic                        receiving_r, receiving_nxt;
  logic                        escaping_r, escaping_nxt;
  logic [sefr_pkg::POS_W-1:0]  count_r, count_nxt;
  logic [sefr_pkg::BYTE_W-1:0] sum_r, sum_nxt;
  logic [sefr_pkg::BYTE_W-1:0] dest_r, dest_nxt;
  logic [sefr_pkg::BYTE_W-1:0] len_r, len_nxt;

  logic [sefr_pkg::BYTE_W-1:0] b;
  logic [sefr_pkg::BYTE_W-1:0] sum_base;
  logic [sefr_pkg::POS_W-1:0]  end_pos;
  logic                        done;

  always_comb begin
    receiving_nxt = receiving_r;
    escaping_nxt  = escaping_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    dest_nxt      = dest_r;
    len_nxt       = len_r;
    res_valid     = 1'b0;
    b             = escaping_r ? item_byte + 8'd1 : item_byte;
    dest_nxt      = (count_r == '0) ? b : dest_r;
    len_nxt       = (count_r == 9'd1) ? b : len_r;
    sum_base      = (count_r == '0) ? '0 : sum_r;
    end_pos       = {1'b0, len_nxt} + 9'd1;
    done          = (count_r != '0) && (count_r == end_pos);
    res.data_byte    = b;
    res.byte_pos     = count_r;
    res.frame_end    = done;
    res.frame_status = sefr_pkg::ST_BUSY;
    if (done) begin
      if (b != sum_base) begin
        res.frame_status = sefr_pkg::ST_SUMERR;
      end else if (dest_nxt == sefr_pkg::BCAST_ADDR || dest_nxt == node_address) begin
        res.frame_status = sefr_pkg::ST_ACCEPT;
      end else begin
        res.frame_status = sefr_pkg::ST_OTHER;
      end
    end
    if (item_byte == sefr_pkg::SYNC_BYTE) begin
      count_nxt     = '0;
      sum_nxt       = '0;
      receiving_nxt = 1'b1;
      escaping_nxt  = 1'b0;
      dest_nxt      = dest_r;
      len_nxt       = len_r;
    end else if (!receiving_r) begin
      dest_nxt = dest_r;
      len_nxt  = len_r;
    end else if (item_byte == sefr_pkg::MARK_BYTE) begin
      escaping_nxt = 1'b1;
      dest_nxt     = dest_r;
      len_nxt      = len_r;
    end else begin
      res_valid    = item_valid;
      escaping_nxt = 1'b0;
      if (done) begin
        count_nxt = '0;
        sum_nxt   = '0;
        if (res.frame_status == sefr_pkg::ST_ACCEPT) begin
          receiving_nxt = 1'b0;
        end
      end else begin
        count_nxt = count_r + 9'd1;
        sum_nxt   = sum_base + b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r <= 1'b0;
      escaping_r  <= 1'b0;
      count_r     <= '0;
      sum_r       <= '0;
      dest_r      <= '0;
      len_r       <= '0;
    end else if (item_valid) begin
      receiving_r <= receiving_nxt;
      escaping_r  <= escaping_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      dest_r      <= dest_nxt;
      len_r       <= len_nxt;
    end
  end

  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.frame_end |-> res.frame_status == sefr_pkg::ST_BUSY)
    else $error("status set on a non-final byte");

  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.frame_status == sefr_pkg::ST_ACCEPT |=> !receiving_r)
    else $error("reception still open after accepted frame");

  a_end_restarts_count: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.frame_end |=> count_r == '0 && sum_r == '0)
    else $error("count not restarted after frame end");

  a_result_clears_escape: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> !escaping_r)
    else $error("escape still armed after a transfer");

endmodule

// ===== hdl/sefr_out_reg.sv =====
module sefr_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  sefr_pkg::result_t res,
  output logic              can_advance,
  output logic              out_valid,
  input  logic              out_ready,
  output sefr_pkg::result_t out_res
);

  logic              valid_r;
  logic              valid_nxt;
  sefr_pkg::result_t res_r;

  assign can_advance = !valid_r || out_ready;
  assign out_valid   = valid_r;
  assign out_res     = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (can_advance) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_advance) begin
      res_r <= res;
    end
  end

endmodule

// ===== hdl/sync_escape_frame_receiver_unit.sv =====
// Receives a byte stream framed by sync 0xE0 with 0xD0 escapes and emits one
// unescaped frame byte per transfer with its position; the checksum byte of
// each frame carries tlast and the frame status in tuser. Sync and escape
// bytes, and bytes outside an open frame, produce no output. One input byte is
// taken every cycle while out_tready does not stall the output; each byte is
// registered in the input register and then in the output register.
// node_address is written through the APB port at offset 0 (reset 0xFF).
module sync_escape_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] data_byte, [16:8] byte_pos, [23:17] zero
  output logic        out_tlast,  // frame_end
  output logic [1:0]  out_tuser,  // [1:0] frame_status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic              item_valid;
  logic [7:0]        item_byte;
  logic              advance;
  logic              res_valid;
  sefr_pkg::result_t res;
  sefr_pkg::result_t out_res;
  logic [7:0]        node_addr_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == 1'b0);
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {24'd0, node_addr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_addr_r <= sefr_pkg::NODE_ADDR_RESET;
    end else if (cfg_wr) begin
      node_addr_r <= cfg_pwdata[7:0];
    end
  end

  sefr_in_reg u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_byte      (in_tdata),
    .item_valid   (item_valid),
    .item_byte    (item_byte),
    .item_advance (advance)
  );

  sefr_frame_fsm u_fsm (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_byte    (item_byte),
    .node_address (node_addr_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  sefr_out_reg u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (res_valid),
    .res         (res),
    .can_advance (advance),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_res     (out_res)
  );

  assign out_tdata = {7'd0, out_res.byte_pos, out_res.data_byte};
  assign out_tlast = out_res.frame_end;
  assign out_tuser = out_res.frame_status;

endmodule
